// ===== rtl/hyperloglog_register_update_defines.svh =====
// Assertion macros shared by the checker of the sketch update block.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef HYPERLOGLOG_REGISTER_UPDATE_DEFINES_SVH
`define HYPERLOGLOG_REGISTER_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on aclk and switched off during reset.
`define HLL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and switched off during reset.
`define HLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hll_pkg.sv =====
// Shared types and constants of the sketch update block.
// Used by the front end, the back end, the top level and the checker.
package hll_pkg;

    localparam int CMD_W      = 2;
    localparam int HASH_W     = 64;
    localparam int SEL_W      = 12;
    localparam int RANK_W     = 6;
    localparam int ZERO_W     = 13;
    localparam int PREC_W     = 4;
    localparam int POS_W      = 7;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MERGE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [RANK_W-1:0] RANK_MAX   = 6'd61;
    localparam logic [PREC_W-1:0] PREC_MIN   = 4'd4;
    localparam logic [PREC_W-1:0] PREC_RESET = 4'd12;

    typedef struct packed {
        logic              update;
        logic [RANK_W-1:0] cand;
    } hll_op_t;

    typedef struct packed {
        logic              clear_req;
        logic [PREC_W-1:0] prec;
    } hll_ctrl_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY
    } hll_state_t;

endpackage

// ===== rtl/hll_queue.sv =====
// Small first-in first-out queue between the front and the back of the block.
// Depends on nothing but its parameters.
module hll_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/hll_front.sv =====
// Front end: holds the precision register, accepts input beats and turns each
// into a bucket index, a candidate rank and an update flag. Uses hll_pkg.
module hll_front
    import hll_pkg::*;
#(
    parameter int IDX_W = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [PREC_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    input  logic                 back_busy,
    input  logic                 q_full,
    output logic                 q_push,
    output logic [IDX_W-1:0]     q_idx,
    output hll_op_t              q_op,
    output hll_ctrl_t            ctrl
);

    logic [PREC_W-1:0] prec_reg;
    logic [PREC_W-1:0] active_p;
    logic [HASH_W-1:0] hash;
    logic [SEL_W-1:0]  sel;
    logic [RANK_W-1:0] merge_rank;
    logic [HASH_W-1:0] zero_map;
    logic [POS_W-1:0]  zero_pos;
    logic [POS_W-1:0]  add_rank;
    logic [RANK_W-1:0] merge_sat;
    logic [IDX_W-1:0]  idx_mask;
    logic [IDX_W-1:0]  idx_raw;

    // Position of the lowest set bit, or 64 when the word is all zeros.
    function automatic logic [POS_W-1:0] first_one(input logic [HASH_W-1:0] v);
        logic [2:0]       byte_pos [8];
        logic [7:0]       byte_any;
        logic [POS_W-1:0] r;
        for (int b = 0; b < 8; b++) begin
            byte_any[b] = |v[8*b +: 8];
            byte_pos[b] = 3'd0;
            for (int i = 7; i >= 0; i--) begin
                if (v[8*b + i]) begin
                    byte_pos[b] = 3'(i);
                end
            end
        end
        r = POS_W'(HASH_W);
        for (int b = 7; b >= 0; b--) begin
            if (byte_any[b]) begin
                r = {1'b0, 3'(b), byte_pos[b]};
            end
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prec_reg <= PREC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            prec_reg <= cfg_data;
        end
    end

    always_comb begin
        active_p = prec_reg;
        if (prec_reg < PREC_MIN) begin
            active_p = PREC_MIN;
        end else if (int'(prec_reg) > IDX_W) begin
            active_p = PREC_W'(IDX_W);
        end
    end

    assign ctrl.clear_req = cfg_valid && cfg_ready;
    assign ctrl.prec      = active_p;

    assign s_tready = !back_busy && !q_full && !cfg_valid;
    assign q_push   = s_tvalid && s_tready;

    assign hash       = s_tdata[HASH_W-1:0];
    assign sel        = s_tdata[HASH_W +: SEL_W];
    assign merge_rank = s_tdata[HASH_W + SEL_W +: RANK_W];

    // The bits below the precision are forced to one, so the first zero bit
    // of the hash at or above the precision gives the rank.
    assign zero_map  = ~(hash | ~({HASH_W{1'b1}} << active_p));
    assign zero_pos  = first_one(zero_map);
    assign add_rank  = zero_pos + 1'b1 - {3'b000, active_p};
    assign merge_sat = (merge_rank > RANK_MAX) ? RANK_MAX : merge_rank;
    assign idx_mask  = ~({IDX_W{1'b1}} << active_p);

    always_comb begin
        case (s_tuser)
            CMD_ADD: begin
                idx_raw     = hash[IDX_W-1:0];
                q_op.cand   = add_rank[RANK_W-1:0];
                q_op.update = 1'b1;
            end
            CMD_MERGE: begin
                idx_raw     = IDX_W'(sel);
                q_op.cand   = merge_sat;
                q_op.update = 1'b1;
            end
            CMD_READ: begin
                idx_raw     = IDX_W'(sel);
                q_op.cand   = '0;
                q_op.update = 1'b0;
            end
            default: begin
                idx_raw     = IDX_W'(sel);
                q_op.cand   = '0;
                q_op.update = 1'b0;
            end
        endcase
    end

    assign q_idx = idx_raw & idx_mask;

endmodule

// ===== rtl/hll_back.sv =====
// Back end: the bucket store with its clearing pass, the read-modify-write of
// one bucket per item, the nonzero count and the result register. Uses hll_pkg.
module hll_back
    import hll_pkg::*;
#(
    parameter int IDX_W = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hll_ctrl_t            ctrl,
    input  logic                 q_valid,
    input  logic [IDX_W-1:0]     q_idx,
    input  hll_op_t              q_op,
    output logic                 q_pop,
    output logic                 busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int DEPTH = 2 ** IDX_W;
    localparam int CNT_W = IDX_W + 1;

    logic [RANK_W-1:0]    store [DEPTH];

    hll_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]     nz_reg, nz_next;
    logic [IDX_W-1:0]     idx_reg;
    hll_op_t              op_reg;
    logic [RANK_W-1:0]    rd_data_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                 out_free;
    logic                 finish;
    logic                 raise;
    logic [RANK_W-1:0]    now_val;
    logic [CNT_W-1:0]     count_all;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [RANK_W-1:0]    wr_data;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign raise     = op_reg.update && (op_reg.cand > rd_data_reg);
    assign now_val   = raise ? op_reg.cand : rd_data_reg;
    assign count_all = CNT_W'(1) << ctrl.prec;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == {IDX_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
        if (ctrl.clear_req) begin
            state_next = ST_CLEAR;
        end
    end

    always_comb begin
        q_pop         = 1'b0;
        busy          = 1'b0;
        finish        = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = op_reg.cand;
        clr_cnt_next  = clr_cnt_reg;
        nz_next       = nz_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_CLEAR: begin
                busy         = 1'b1;
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                nz_next      = '0;
            end
            ST_IDLE: begin
                q_pop = q_valid && !ctrl.clear_req;
            end
            ST_MODIFY: begin
                finish = out_free;
                wr_en  = out_free && raise;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (raise && (rd_data_reg == '0)) begin
                        nz_next = nz_reg + 1'b1;
                    end
                end
            end
            default: begin
                busy = 1'b1;
            end
        endcase
        if (ctrl.clear_req) begin
            clr_cnt_next = '0;
            nz_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            nz_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            nz_reg       <= nz_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            idx_reg <= q_idx;
            op_reg  <= q_op;
        end
        if (finish) begin
            m_tdata_reg <= {raise, ZERO_W'(count_all - nz_next), now_val, SEL_W'(idx_reg)};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= wr_data;
        end
        if (q_pop) begin
            rd_data_reg <= store[q_idx];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/hyperloglog_register_update.sv =====
// Sketch update block: 2**LOG2_BUCKETS_MAX six-bit bucket registers, of which
// 2**precision are active, updated by add, merge and read beats. After reset
// and after every precision write the store is cleared one bucket a cycle, and
// s_tready stays low until all 2**LOG2_BUCKETS_MAX buckets are cleared.
// Each item is then read from the single-port bucket store in ST_IDLE and, if
// raised, written back in ST_MODIFY. When the block is idle, an accepted input
// beat passes the queue, ST_IDLE and ST_MODIFY before its result is offered.
module hyperloglog_register_update
    import hll_pkg::*;
#(
    parameter int LOG2_BUCKETS_MAX = 12,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [PREC_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // hash_value [63:0], bucket_select [75:64], merge_rank [81:76], zeros above
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd [1:0]
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // bucket_index [11:0], bucket_value [17:12], zero_buckets [30:18], raised [31]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = LOG2_BUCKETS_MAX;
    localparam int Q_W   = IDX_W + $bits(hll_op_t);

    logic             back_busy;
    logic             q_full, q_push, q_pop, q_valid;
    logic [IDX_W-1:0] f_idx, b_idx;
    hll_op_t          f_op, b_op;
    hll_ctrl_t        ctrl;
    logic [Q_W-1:0]   q_in, q_out;

    assign q_in          = {f_idx, f_op};
    assign {b_idx, b_op} = q_out;

    hll_front #(
        .IDX_W(IDX_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .back_busy (back_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_idx     (f_idx),
        .q_op      (f_op),
        .ctrl      (ctrl)
    );

    hll_queue #(
        .DATA_W(Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .valid     (q_valid)
    );

    hll_back #(
        .IDX_W(IDX_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .q_valid  (q_valid),
        .q_idx    (b_idx),
        .q_op     (b_op),
        .q_pop    (q_pop),
        .busy     (back_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/hll_checker.sv =====
// Port-level checks of the sketch update block, bound to its top level.
// Uses hll_pkg and the assertion macros of the defines header.
`include "hyperloglog_register_update_defines.svh"

module hll_checker
    import hll_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A result beat that is not taken stays offered and unchanged.
    `HLL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // A raised bucket cannot hold zero.
    `HLL_ASSERT_IMPL(a_raise_nonzero, m_tvalid && m_tdata[31], m_tdata[17:12] != 6'd0, "raised bucket reports zero")

    // A precision write starts the clearing pass, which blocks input beats.
    `HLL_ASSERT_NEXT(a_cfg_clears, cfg_valid && cfg_ready, !s_tready, "input accepted during clearing pass")

endmodule

bind hyperloglog_register_update hll_checker u_hll_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
